### hw/rtl/pba_pkg.sv
package pba_pkg;

    localparam int WORD_BITS = 32;
    localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_SPACE  = 2'd1,
        STATUS_BAD_COUNT = 2'd2,
        STATUS_RANGE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_ADDR,
        ST_FCHK,
        ST_FRD,
        ST_FWR,
        ST_RESP
    } state_t;

    // result of the in-word window search
    typedef struct packed {
        logic       found;
        logic [4:0] start;
    } fit_t;

endpackage

### hw/rtl/pba_map_ram.sv
module pba_map_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [pba_pkg::WORD_BITS-1:0] wdata,
    input  logic [AW-1:0]                 raddr,
    output logic [pba_pkg::WORD_BITS-1:0] rdata
);

    logic [pba_pkg::WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/pba_window_find.sv
module pba_window_find (
    input  logic [pba_pkg::WORD_BITS-1:0] word,
    input  logic [5:0]                    count,
    output pba_pkg::fit_t                 fit,
    output logic [pba_pkg::WORD_BITS-1:0] mask
);

    logic [pba_pkg::WORD_BITS-1:0] win;
    logic [pba_pkg::WORD_BITS-1:0] fit_vec;
    logic [4:0]                    start;

    always_comb
    begin
        win     = '0;
        fit_vec = '0;
        start   = '0;
        for (int i = 0; i < pba_pkg::WORD_BITS; i++)
        begin
            win[i] = (6'(i) < count);
        end
        // a window may start at s only if it ends inside the word
        for (int s = 0; s < pba_pkg::WORD_BITS; s++)
        begin
            fit_vec[s] = ((7'(s) + 7'(count)) <= 7'(pba_pkg::WORD_BITS))
                         && ((word & (win << s)) == '0);
        end
        // take the lowest fitting start
        for (int s = pba_pkg::WORD_BITS - 1; s >= 0; s--)
        begin
            if (fit_vec[s])
            begin
                start = 5'(s);
            end
        end
        fit.found = |fit_vec;
        fit.start = start;
        mask      = win << start;
    end

endmodule

### hw/rtl/page_bitmap_allocator_unit.sv
// Page frame allocator over a used-page bitmap of MAP_WORDS 32-bit words held in one
// synchronous RAM; page p lives at pool_base + p * PAGE_BYTES (PAGE_BYTES must be a
// power of two). After reset a clearing pass writes every bitmap word to zero, one
// word a cycle, so no request is taken until the pass has reached the last word;
// pool_base writes are taken at any time. Requests are handled one at a time. A free
// goes through a range check and, if the address is in range, a RAM read and a
// write-back before the output. An allocate scans bitmap words from index 0 with one
// RAM read per cycle, pipelined against the window search on the previous word, and
// stops at the first word that fits or reports no space after the last word; a bad
// count goes straight to the output. The result sits in an output register, so the
// next request is accepted while a result waits on m_axis_tready.
module page_bitmap_allocator_unit #(
    parameter int MAP_WORDS  = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,     // pool_base
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // page_count[5:0], free_address[37:6], zero pad
    input  logic        s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // status[1:0], page_address[33:2],
                                       // page_number[48:34], zero pad
);

    localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PW         = AW + 5;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [AW-1:0] LAST_WORD   = AW'(MAP_WORDS - 1);
    localparam logic [31:0]   PAGE_LIMIT  = 32'(MAP_WORDS * pba_pkg::WORD_BITS);
    localparam logic [31:0]   OFFSET_MASK = 32'(PAGE_BYTES - 1);

    pba_pkg::state_t state_reg, state_next;

    logic [31:0]   pool_base_reg;
    logic [AW-1:0] clr_ptr_reg, clr_ptr_next;
    logic [AW-1:0] scan_ptr_reg, scan_ptr_next;
    logic          issue_reg, issue_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          m_valid_reg, m_valid_next;

    logic [5:0]       req_count_reg, req_count_next;
    logic [31:0]      req_addr_reg, req_addr_next;
    pba_pkg::status_t res_status_reg, res_status_next;
    logic [31:0]      res_addr_reg, res_addr_next;
    logic [PW-1:0]    res_page_reg, res_page_next;
    logic [48:0]      m_data_reg, m_data_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    pba_pkg::fit_t fit;
    logic [31:0]   fit_mask;

    logic [31:0] aligned;
    logic [31:0] diff;
    logic [31:0] free_page;
    logic        in_accept;

    pba_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pba_window_find u_find (
        .word  (mem_rdata),
        .count (req_count_reg),
        .fit   (fit),
        .mask  (fit_mask)
    );

    assign s_axis_tready = (state_reg == pba_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_data_reg};

    assign aligned   = req_addr_reg & ~OFFSET_MASK;
    assign diff      = aligned - pool_base_reg;
    assign free_page = diff >> PAGE_SHIFT;

    always_comb
    begin
        state_next      = state_reg;
        clr_ptr_next    = clr_ptr_reg;
        scan_ptr_next   = scan_ptr_reg;
        issue_next      = issue_reg;
        rd_valid_next   = rd_valid_reg;
        rd_idx_next     = rd_idx_reg;
        m_valid_next    = m_valid_reg;
        req_count_next  = req_count_reg;
        req_addr_next   = req_addr_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_page_next   = res_page_reg;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = '0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            pba_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_ptr_reg;
                if (clr_ptr_reg == LAST_WORD)
                begin
                    state_next = pba_pkg::ST_IDLE;
                end
                else
                begin
                    clr_ptr_next = clr_ptr_reg + 1'b1;
                end
            end

            pba_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    req_count_next = s_axis_tdata[5:0];
                    req_addr_next  = s_axis_tdata[37:6];
                    res_addr_next  = '0;
                    res_page_next  = '0;
                    if (s_axis_tuser == pba_pkg::REQ_FREE)
                    begin
                        state_next = pba_pkg::ST_FCHK;
                    end
                    else if (s_axis_tdata[5:0] == 6'd0 || s_axis_tdata[5:0] > 6'd32)
                    begin
                        res_status_next = pba_pkg::STATUS_BAD_COUNT;
                        state_next      = pba_pkg::ST_RESP;
                    end
                    else
                    begin
                        scan_ptr_next = '0;
                        issue_next    = 1'b1;
                        rd_valid_next = 1'b0;
                        state_next    = pba_pkg::ST_SCAN;
                    end
                end
            end

            pba_pkg::ST_SCAN:
            begin
                mem_raddr = scan_ptr_reg;
                if (rd_valid_reg && fit.found)
                begin
                    // mark the window used; no other write is in flight
                    mem_we        = 1'b1;
                    mem_waddr     = rd_idx_reg;
                    mem_wdata     = mem_rdata | fit_mask;
                    res_page_next = {rd_idx_reg, fit.start};
                    state_next    = pba_pkg::ST_ADDR;
                end
                else if (rd_valid_reg && rd_idx_reg == LAST_WORD)
                begin
                    res_status_next = pba_pkg::STATUS_NO_SPACE;
                    state_next      = pba_pkg::ST_RESP;
                end
                else
                begin
                    rd_valid_next = issue_reg;
                    rd_idx_next   = scan_ptr_reg;
                    if (scan_ptr_reg == LAST_WORD)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_ptr_next = scan_ptr_reg + 1'b1;
                    end
                end
            end

            pba_pkg::ST_ADDR:
            begin
                res_status_next = pba_pkg::STATUS_OK;
                res_addr_next   = pool_base_reg + (32'(res_page_reg) << PAGE_SHIFT);
                state_next      = pba_pkg::ST_RESP;
            end

            pba_pkg::ST_FCHK:
            begin
                if (aligned < pool_base_reg || free_page >= PAGE_LIMIT)
                begin
                    res_status_next = pba_pkg::STATUS_RANGE;
                    state_next      = pba_pkg::ST_RESP;
                end
                else
                begin
                    res_status_next = pba_pkg::STATUS_OK;
                    res_addr_next   = aligned;
                    res_page_next   = free_page[PW-1:0];
                    state_next      = pba_pkg::ST_FRD;
                end
            end

            pba_pkg::ST_FRD:
            begin
                mem_raddr  = res_page_reg[PW-1:5];
                state_next = pba_pkg::ST_FWR;
            end

            pba_pkg::ST_FWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = res_page_reg[PW-1:5];
                mem_wdata  = mem_rdata & ~(32'd1 << res_page_reg[4:0]);
                state_next = pba_pkg::ST_RESP;
            end

            pba_pkg::ST_RESP:
            begin
                // hold until the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {15'(32'(res_page_reg)), res_addr_reg, res_status_reg};
                    state_next   = pba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pba_pkg::ST_CLEAR;
            pool_base_reg <= '0;
            clr_ptr_reg   <= '0;
            scan_ptr_reg  <= '0;
            issue_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            scan_ptr_reg  <= scan_ptr_next;
            issue_reg     <= issue_next;
            rd_valid_reg  <= rd_valid_next;
            rd_idx_reg    <= rd_idx_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we)
            begin
                pool_base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_count_reg  <= req_count_next;
        req_addr_reg   <= req_addr_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_page_reg   <= res_page_next;
        m_data_reg     <= m_data_next;
    end

endmodule

### hw/rtl/pba_checker.sv
module pba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    // one request at a time: an accepted request closes the input side
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in progress");

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // failed requests report zero address and page
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != pba_pkg::STATUS_OK
        |-> m_axis_tdata[48:2] == '0)
        else $error("failure result carries address or page");

    // no result shows up in the cycle right after acceptance
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared without processing time");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:49] == '0)
        else $error("result pad bits not zero");

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (.*);

### verif/tb_page_bitmap_allocator_unit.sv
`timescale 1ns / 1ps

module tb_page_bitmap_allocator_unit;

    localparam int MAP_WORDS  = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int POOL_PAGES = MAP_WORDS * pba_pkg::WORD_BITS;

    typedef struct {
        pba_pkg::status_t status;
        logic [31:0]      address;
        logic [14:0]      page;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // page_count[5:0], free_address[37:6], zero pad
    logic        s_axis_tuser;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // status[1:0], page_address[33:2], page_number[48:34]

    // mirror of the used-page bitmap and pool base
    logic [31:0] page_map [MAP_WORDS];
    logic [31:0] base_addr;
    int unsigned live_pages [$];
    reply_t      outstanding_replies [$];

    int mismatches;
    int send_idle_pct;
    int stall_pct;
    int hold_left;

    page_bitmap_allocator_unit #(
        .MAP_WORDS  (MAP_WORDS),
        .PAGE_BYTES (PAGE_BYTES)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tb_page_bitmap_allocator_unit NOT OK");
        $finish;
    end

    // Apply one request to the bitmap mirror and return the reply it gives.
    function automatic reply_t bitmap_reply(logic kind, logic [5:0] count, logic [31:0] addr);
        reply_t      r;
        logic [31:0] win;
        logic [31:0] m;
        logic [31:0] aligned;
        logic [31:0] pg;
        r.status  = pba_pkg::STATUS_OK;
        r.address = '0;
        r.page    = '0;
        if (kind == pba_pkg::REQ_ALLOC)
        begin
            if (count == 0 || count > pba_pkg::WORD_BITS)
            begin
                r.status = pba_pkg::STATUS_BAD_COUNT;
                return r;
            end
            win = pba_pkg::FULL_WORD >> (pba_pkg::WORD_BITS - count);
            for (int w = 0; w < MAP_WORDS; w++)
            begin
                if (page_map[w] == pba_pkg::FULL_WORD)
                    continue;
                for (int s = 0; s <= pba_pkg::WORD_BITS - count; s++)
                begin
                    m = win << s;
                    if ((page_map[w] & m) == '0)
                    begin
                        page_map[w] = page_map[w] | m;
                        pg = w * pba_pkg::WORD_BITS + s;
                        r.address = base_addr + pg * PAGE_BYTES;
                        r.page    = pg[14:0];
                        for (int i = 0; i < count; i++)
                            live_pages.push_back(pg + i);
                        return r;
                    end
                end
            end
            r.status = pba_pkg::STATUS_NO_SPACE;
            return r;
        end
        aligned = addr - (addr % 32'(PAGE_BYTES));
        if (aligned < base_addr)
        begin
            r.status = pba_pkg::STATUS_RANGE;
            return r;
        end
        pg = (aligned - base_addr) / 32'(PAGE_BYTES);
        if (pg >= POOL_PAGES)
        begin
            r.status = pba_pkg::STATUS_RANGE;
            return r;
        end
        page_map[pg / pba_pkg::WORD_BITS][pg % pba_pkg::WORD_BITS] = 1'b0;
        r.address = aligned;
        r.page    = pg[14:0];
        return r;
    endfunction

    task automatic send_req(logic kind, logic [5:0] count, logic [31:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, addr, count};
        do
            @(posedge clk);
        while (!s_axis_tready);
        outstanding_replies.push_back(bitmap_reply(kind, count, addr));
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (outstanding_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_pool(logic [31:0] value);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        base_addr = value;
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        set_pool(32'h0000_0000);
        send_req(pba_pkg::REQ_ALLOC, 6'd1, 32'h0);
        send_req(pba_pkg::REQ_ALLOC, 6'd32, 32'h0);           // word 0 cannot hold 32 more
        send_req(pba_pkg::REQ_ALLOC, 6'd0, 32'hFFFF_FFFF);
        send_req(pba_pkg::REQ_ALLOC, 6'd33, 32'h0);
        send_req(pba_pkg::REQ_ALLOC, 6'd63, 32'h0);
        send_req(pba_pkg::REQ_ALLOC, 6'd31, 32'h0);
        send_req(pba_pkg::REQ_ALLOC, 6'd1, 32'h0);            // word 0 now full, skip it
        send_req(pba_pkg::REQ_FREE, 6'd0, 32'h0000_0FFF);
        send_req(pba_pkg::REQ_FREE, 6'd0, 32'h0000_0000);     // page already free
        send_req(pba_pkg::REQ_FREE, 6'd0, 32'h0800_0000);     // one past the pool
        send_req(pba_pkg::REQ_FREE, 6'd0, 32'hFFFF_FFFF);
        send_req(pba_pkg::REQ_ALLOC, 6'd2, 32'hA5A5_5A5A);
        send_req(pba_pkg::REQ_FREE, 6'h3F, 32'h0002_0ABC);

        // base near the top: addresses wrap past zero
        set_pool(32'hFFFF_F000);
        send_req(pba_pkg::REQ_ALLOC, 6'd1, 32'h0);
        send_req(pba_pkg::REQ_ALLOC, 6'd4, 32'h0);
        send_req(pba_pkg::REQ_FREE, 6'd0, 32'h0000_0000);
        send_req(pba_pkg::REQ_FREE, 6'd0, 32'hFFFF_EABC);
        send_req(pba_pkg::REQ_FREE, 6'd0, 32'hFFFF_F123);

        set_pool(32'hFFFF_FFFF);
        send_req(pba_pkg::REQ_ALLOC, 6'd3, 32'h0);
        send_req(pba_pkg::REQ_FREE, 6'd0, 32'hFFFF_FFFF);

        set_pool(32'h1234_5000);
        send_req(pba_pkg::REQ_FREE, 6'd0, 32'h1234_4FFF);
        send_req(pba_pkg::REQ_FREE, 6'd0, 32'h1A34_4000);     // last page of the pool
        send_req(pba_pkg::REQ_FREE, 6'd0, 32'h1A34_5000);
    endtask

    task automatic test_random_phase(logic [31:0] pool, int sidle, int rstall, int n_items);
        int          r;
        int          idx;
        int unsigned pg;
        logic [5:0]  cnt;
        logic [31:0] addr;
        set_pool(pool);
        send_idle_pct = sidle;
        stall_pct     = rstall;
        repeat (n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    cnt = 6'($urandom_range(1, 4));
                else if (r < 93)
                    cnt = 6'($urandom_range(5, 32));
                else if (r < 96)
                    cnt = 6'd0;
                else
                    cnt = 6'($urandom_range(33, 63));
                send_req(pba_pkg::REQ_ALLOC, cnt, $urandom());
            end
            else
            begin
                cnt = 6'($urandom_range(0, 63));
                if (r < 85 && live_pages.size() != 0)
                begin
                    idx = $urandom_range(0, live_pages.size() - 1);
                    pg  = live_pages[idx];
                    live_pages.delete(idx);
                    addr = base_addr + pg * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
                end
                else if (r < 92)
                begin
                    // just outside either end of the pool
                    if ($urandom_range(0, 1))
                        addr = base_addr - $urandom_range(1, 2 * PAGE_BYTES);
                    else
                        addr = base_addr + POOL_PAGES * PAGE_BYTES
                               + $urandom_range(0, 2 * PAGE_BYTES);
                end
                else
                    addr = $urandom();
                send_req(pba_pkg::REQ_FREE, cnt, addr);
            end
        end
    endtask

    task automatic test_backpressure();
        set_pool(32'h0040_0000);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 400;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 3 == 2 && live_pages.size() != 0)
                send_req(pba_pkg::REQ_FREE, 6'd0,
                         base_addr + live_pages.pop_front() * PAGE_BYTES);
            else
                send_req(pba_pkg::REQ_ALLOC, 6'($urandom_range(1, 8)), 32'h0);
        end
        // pause until the block has answered everything
        wait_drain();
        for (int i = 0; i < 6; i++)
            send_req(pba_pkg::REQ_ALLOC, 6'($urandom_range(1, 32)), 32'h0);
    endtask

    task automatic test_fill_no_space();
        int empties;
        set_pool(32'h0000_0000);
        send_idle_pct = 0;
        stall_pct     = 0;
        empties = 0;
        foreach (page_map[w])
            if (page_map[w] == '0)
                empties++;
        // take every empty word, leaving no room for a full-word request
        repeat (empties)
            send_req(pba_pkg::REQ_ALLOC, 6'd32, $urandom());
        send_req(pba_pkg::REQ_ALLOC, 6'd32, 32'h0);
        send_req(pba_pkg::REQ_ALLOC, 6'd33, 32'h0);
        send_req(pba_pkg::REQ_FREE, 6'd0,
                 base_addr + (1000 * pba_pkg::WORD_BITS + 7) * PAGE_BYTES);
        send_req(pba_pkg::REQ_ALLOC, 6'd1, 32'h0);
        send_req(pba_pkg::REQ_ALLOC, 6'd32, 32'h0);
        stall_pct = 71;
        send_req(pba_pkg::REQ_ALLOC, 6'd7, 32'h0);
        send_req(pba_pkg::REQ_FREE, 6'd0,
                 base_addr + (MAP_WORDS * pba_pkg::WORD_BITS - 1) * PAGE_BYTES);
        send_req(pba_pkg::REQ_ALLOC, 6'd1, 32'h0);
    endtask

    // receiver side: random stalls, plus a counted hold-off when asked
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_replies
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (outstanding_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply with no request pending: %h", m_axis_tdata);
            end
            else
            begin
                want = outstanding_replies.pop_front();
                if (m_axis_tdata[1:0] !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("status: expected %0d got %0d", want.status,
                                 m_axis_tdata[1:0]);
                end
                if (m_axis_tdata[33:2] !== want.address)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("page_address: expected %h got %h", want.address,
                                 m_axis_tdata[33:2]);
                end
                if (m_axis_tdata[48:34] !== want.page)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("page_number: expected %0d got %0d", want.page,
                                 m_axis_tdata[48:34]);
                end
            end
        end
    end

    initial
    begin
        int guard;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        mismatches    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 0;
        base_addr     = '0;
        foreach (page_map[w])
            page_map[w] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_phase(32'h0000_0000, 0, 0, 100);
        test_random_phase(32'h8000_0000, 71, 0, 100);
        test_random_phase({20'($urandom_range(0, 32'hF_FFFF)), 12'h000}, 0, 71, 100);
        test_random_phase($urandom(), 19, 19, 100);
        test_backpressure();
        test_fill_no_space();

        s_axis_tvalid <= 1'b0;
        for (guard = 0; guard < 20000 && outstanding_replies.size() != 0; guard++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        mismatches += outstanding_replies.size();
        if (mismatches == 0)
            $display("tb_page_bitmap_allocator_unit OK");
        else
            $display("tb_page_bitmap_allocator_unit NOT OK");
        $finish;
    end

endmodule
